[src/btm_pkg.sv]
// Package for the byte-tracked memory: opcodes, status codes, the bank entry
// layout and the request and response structs shared by the lanes and the top level.
// No dependencies.
package btm_pkg;

  // Eight byte banks serve any unaligned access of up to eight bytes in one look-up.
  localparam int unsigned BANKS            = 8;
  localparam int unsigned BANK_W           = 3;
  localparam int unsigned MAX_ACCESS_BYTES = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_IMAGE = 2'd2,
    OP_BAD   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DEFINED    = 2'd0,
    ST_SOME_UNDEF = 2'd1,
    ST_ALL_FREE   = 2'd2,
    ST_ERROR      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  // One byte of simulated memory as stored in a bank.
  typedef struct packed {
    logic       img_valid;
    logic       free;
    logic [7:0] img;
    logic [7:0] cur;
  } byte_ent_t;

  localparam int unsigned ENT_W = $bits(byte_ent_t);

  // Per-transaction controls that every lane sees.
  typedef struct packed {
    opcode_t op;
    logic    set_initial;
    logic    copy_free;
  } lane_req_t;

  typedef struct packed {
    logic      we;
    byte_ent_t wr_ent;
    logic [7:0] rd_byte;
    logic      undef;
  } lane_rsp_t;

  localparam logic [1:0] ADDR_FILL = 2'd0;

endpackage

[src/btm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module btm_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/btm_lane.sv]
// One byte lane: merges a bank entry read with the transaction and forms the
// write-back entry, the byte returned and the undefined flag. Uses btm_pkg.
module btm_lane
  import btm_pkg::*;
(
  input  lane_req_t  req,
  input  logic       en,
  input  logic [7:0] wr_byte,
  input  logic [7:0] fill_value,
  input  byte_ent_t  rd_ent,
  output lane_rsp_t  rsp
);

  logic [7:0] img_byte;

  always_comb begin
    img_byte    = rd_ent.img_valid ? rd_ent.img : fill_value;
    rsp.we      = 1'b0;
    rsp.wr_ent  = rd_ent;
    rsp.rd_byte = 8'd0;
    rsp.undef   = 1'b0;
    unique case (req.op)
      OP_WRITE: begin
        rsp.we         = en;
        rsp.wr_ent.cur  = wr_byte;
        rsp.wr_ent.free = 1'b0;
        if (req.set_initial) begin
          rsp.wr_ent.img       = wr_byte;
          rsp.wr_ent.img_valid = 1'b1;
        end
      end
      OP_READ: begin
        rsp.undef   = rd_ent.free;
        rsp.rd_byte = rd_ent.free ? img_byte : rd_ent.cur;
        if (rd_ent.free && req.copy_free) begin
          // Copy on read: a free byte takes the image or fill byte as contents.
          rsp.we          = en;
          rsp.wr_ent.cur  = img_byte;
          rsp.wr_ent.free = 1'b0;
        end
      end
      OP_IMAGE: begin
        rsp.rd_byte = img_byte;
      end
      default: begin
      end
    endcase
  end

endmodule

[src/byte_tracked_memory_with_initial_image.sv]
// Top level of the byte-tracked memory with initial image.
// Uses btm_pkg, btm_ram (one per byte bank) and btm_lane (one per byte bank).
//
// Byte memory for a simulated machine. Every byte carries its current value, a
// free mark, an initial-image byte and an image valid bit, all kept together in
// eight byte-interleaved banks so that any access of one to eight bytes, aligned
// or not, touches each bank at most once. A transaction is accepted when the block
// is idle; the next cycle the bank words come back. Once the output register can
// take a result, each lane merges them with the request, the result is loaded into
// the output register and modified words are written back, in a single
// read-modify-write pass through the bank memories. A result may wait in the output
// register while the next transaction is already being looked up; that look-up
// holds until the output register frees up. After reset the block runs a clearing
// pass over every row of the banks that marks every byte free with no image; no
// transaction is accepted during that pass, but the fill value register can be
// written at any time. Errors (bad opcode, length outside 1 to 8, or an access
// running past the end) answer status 3 with zero data and touch nothing. The
// fill value register is at byte address 0.
module byte_tracked_memory_with_initial_image
  import btm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_address,
  input  logic [3:0]  in_length,
  input  logic [63:0] in_write_data,
  input  logic        in_set_initial,
  input  logic        in_init_if_free,
  // Result transactions
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_read_data,
  output logic [1:0]  out_status,
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // A 16-bit start address plus up to eight bytes bounds the reachable bytes.
  localparam int unsigned MEM_DEPTH = (MEM_BYTES < 65544) ? MEM_BYTES : 65544;
  localparam int unsigned ROWS      = (MEM_DEPTH + BANKS - 1) / BANKS;
  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam logic [24:0] MEM_LIMIT = 25'(MEM_BYTES);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [7:0] fill_value_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_value_r <= 8'd0;
    end else if (cfg_wr && (cfg_paddr == ADDR_FILL)) begin
      fill_value_r <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == ADDR_FILL) ? {24'd0, fill_value_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t         state_r, state_nxt;
  logic [ROW_W-1:0] clr_row_r, clr_row_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           accept;
  logic           fire;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // The look-up completes once the output register can take its result.
  assign fire     = (state_r == S_LOOK) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_row_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_row_r   <= clr_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_row_nxt   = clr_row_r;
    out_valid_nxt = fire || (out_valid_r && !out_ready);
    unique case (state_r)
      S_CLEAR: begin
        clr_row_nxt = clr_row_r + ROW_W'(1);
        if (clr_row_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request decode at acceptance
  // ---------------------------------------------------------------------------
  logic [24:0] end_addr;
  logic        req_err;
  logic [12:0] base_row;
  logic [ROW_W-1:0] in_row [BANKS];
  logic [BANKS-1:0] in_en;

  assign end_addr = {9'd0, in_address} + {21'd0, in_length};
  assign req_err  = (opcode_t'(in_opcode) == OP_BAD) || (in_length == 4'd0) ||
                    (in_length > 4'(MAX_ACCESS_BYTES)) || (end_addr > MEM_LIMIT);
  assign base_row = in_address[15:3];

  always_comb begin
    logic [BANK_W-1:0] idx;
    logic [13:0]       row_full;
    for (int b = 0; b < BANKS; b++) begin
      idx      = BANK_W'(b) - in_address[BANK_W-1:0];
      // Banks below the start offset hold bytes of the next row.
      row_full = {1'b0, base_row} +
                 14'((BANK_W'(b) < in_address[BANK_W-1:0]) ? 1 : 0);
      in_row[b] = row_full[ROW_W-1:0];
      in_en[b]  = !req_err && ({1'b0, idx} < in_length);
    end
  end

  // Transaction held during the look-up cycle(s).
  lane_req_t        req_r;
  logic             err_r;
  logic [BANK_W-1:0] addr_lo_r;
  logic [63:0]      wdata_r;
  logic [ROW_W-1:0] row_r [BANKS];
  logic [BANKS-1:0] en_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op           <= opcode_t'(in_opcode);
      req_r.set_initial  <= in_set_initial;
      req_r.copy_free    <= in_init_if_free;
      err_r              <= req_err;
      addr_lo_r          <= in_address[BANK_W-1:0];
      wdata_r            <= in_write_data;
      row_r              <= in_row;
      en_r               <= in_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte banks and lanes
  // ---------------------------------------------------------------------------
  byte_ent_t        rd_ent [BANKS];
  lane_rsp_t        rsp [BANKS];
  logic [BANKS-1:0] bank_we;
  logic [BANKS-1:0] undef_vec;
  logic [7:0]       lane_byte [BANKS];

  localparam byte_ent_t CLEAR_ENT = '{img_valid: 1'b0, free: 1'b1, img: 8'd0, cur: 8'd0};

  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [BANK_W-1:0] lane_idx;
    logic [7:0]        wr_byte;
    logic [ROW_W-1:0]  waddr;
    byte_ent_t         wdata;
    logic [ENT_W-1:0]  rdata;

    assign lane_idx = BANK_W'(b) - addr_lo_r;
    assign wr_byte  = wdata_r[8*lane_idx +: 8];

    btm_lane u_lane (
      .req       (req_r),
      .en        (en_r[b]),
      .wr_byte   (wr_byte),
      .fill_value(fill_value_r),
      .rd_ent    (rd_ent[b]),
      .rsp       (rsp[b])
    );

    assign bank_we[b]   = (state_r == S_CLEAR) || (fire && rsp[b].we);
    assign waddr        = (state_r == S_CLEAR) ? clr_row_r : row_r[b];
    assign wdata        = (state_r == S_CLEAR) ? CLEAR_ENT : rsp[b].wr_ent;
    assign rd_ent[b]    = byte_ent_t'(rdata);
    assign undef_vec[b] = rsp[b].undef;
    assign lane_byte[b] = rsp[b].rd_byte;

    btm_ram #(
      .WIDTH(ENT_W),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (bank_we[b]),
      .waddr(waddr),
      .wdata(ENT_W'(wdata)),
      .re   (accept),
      .raddr(in_row[b]),
      .rdata(rdata)
    );
  end

  // ---------------------------------------------------------------------------
  // Result assembly and output register
  // ---------------------------------------------------------------------------
  logic [63:0] res_data;
  status_t     res_status;
  logic [63:0] out_read_data_r;
  status_t     out_status_r;

  always_comb begin
    logic [BANK_W-1:0] sel;
    res_data = 64'd0;
    for (int i = 0; i < BANKS; i++) begin
      sel = addr_lo_r + BANK_W'(i);
      if (en_r[sel] && (req_r.op != OP_WRITE)) begin
        res_data[8*i +: 8] = lane_byte[sel];
      end
    end
    if (err_r) begin
      res_status = ST_ERROR;
    end else if (req_r.op != OP_READ) begin
      res_status = ST_DEFINED;
    end else if (&(~en_r | undef_vec)) begin
      res_status = ST_ALL_FREE;
    end else if (|(en_r & undef_vec)) begin
      res_status = ST_SOME_UNDEF;
    end else begin
      res_status = ST_DEFINED;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data_r <= res_data;
      out_status_r    <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = 2'(out_status_r);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_LOOK))
    else $error("result appeared without a look-up");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("transaction accepted during clearing pass");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (bank_we == '0))
    else $error("bank written while idle");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_ERROR)) |-> (out_read_data_r == 64'd0))
    else $error("error result carries data");

  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && err_r) |-> (bank_we == '0))
    else $error("erroneous transaction modified memory");

endmodule

[sim/byte_tracked_memory_with_initial_image_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for byte_tracked_memory_with_initial_image.
// Depends on btm_pkg and the block's RTL; it keeps its own byte-level memory image to predict results.
module byte_tracked_memory_with_initial_image_tb;
  import btm_pkg::*;

  localparam int unsigned MEM_SIZE = 65536;

  // One expected answer: the packed read bytes and the status code.
  typedef struct {
    logic [63:0] data;
    status_t     status;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic [15:0] in_address;
  logic [3:0]  in_length;
  logic [63:0] in_write_data;
  logic        in_set_initial;
  logic        in_init_if_free;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_read_data;
  logic [1:0]  out_status;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the simulated memory: current byte, free mark, image byte and
  // image valid bit for every address, plus the fill value register.
  bit [7:0] mem_cur    [MEM_SIZE];
  bit       mem_free   [MEM_SIZE];
  bit [7:0] mem_img    [MEM_SIZE];
  bit       mem_img_ok [MEM_SIZE];
  bit [7:0] fill_byte;

  // Answers owed by the block, oldest first.
  access_result_t due_results[$];

  int n_errors;
  int n_sent;
  int n_checked;
  int n_fill_writes;
  int status_count[4];

  // Idle rates for the two sides, in percent of cycles.
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;

  // The receiver counts a requested hold-off itself; a test asks for one by
  // loading hold_len and toggling hold_toggle.
  bit          hold_toggle;
  bit          hold_seen;
  int unsigned hold_len;
  int unsigned hold_left;

  // Base of the address window that most random traffic lands in, so that
  // reads find a mix of written, copied and still free bytes.
  int unsigned win_base;

  byte_tracked_memory_with_initial_image dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_length       (in_length),
    .in_write_data   (in_write_data),
    .in_set_initial  (in_set_initial),
    .in_init_if_free (in_init_if_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_status      (out_status),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #4 clk = ~clk;

  // Works out the answer to one transaction and applies its side effects to the
  // shadow memory. Errors touch nothing. A read counts the bytes that were still
  // free; those return the image byte, or the fill value in force right now when
  // no image byte was ever set, and are copied into current memory on request.
  function automatic access_result_t compute_access_result(
    opcode_t op, logic [15:0] addr, logic [3:0] len, logic [63:0] wdata,
    logic set_init, logic fill_free
  );
    access_result_t res;
    int unsigned    a;
    int unsigned    undef_cnt;
    bit [7:0]       b;
    res.data   = '0;
    res.status = ST_DEFINED;
    undef_cnt  = 0;
    if (op == OP_BAD || len == 0 || len > MAX_ACCESS_BYTES ||
        int'(addr) + int'(len) > MEM_SIZE) begin
      res.status = ST_ERROR;
      return res;
    end
    for (int i = 0; i < int'(len); i++) begin
      a = int'(addr) + i;
      case (op)
        OP_WRITE: begin
          b = wdata[8*i +: 8];
          mem_cur[a]  = b;
          mem_free[a] = 1'b0;
          if (set_init) begin
            mem_img[a]    = b;
            mem_img_ok[a] = 1'b1;
          end
        end
        OP_IMAGE: begin
          res.data[8*i +: 8] = mem_img_ok[a] ? mem_img[a] : fill_byte;
        end
        default: begin
          if (mem_free[a]) begin
            b = mem_img_ok[a] ? mem_img[a] : fill_byte;
            if (fill_free) begin
              mem_cur[a]  = b;
              mem_free[a] = 1'b0;
            end
            undef_cnt++;
          end else begin
            b = mem_cur[a];
          end
          res.data[8*i +: 8] = b;
        end
      endcase
    end
    if (op == OP_READ) begin
      if (undef_cnt == len) res.status = ST_ALL_FREE;
      else if (undef_cnt > 0) res.status = ST_SOME_UNDEF;
    end
    return res;
  endfunction

  // Offers one transaction, first idling for a random number of cycles at the
  // sender's idle rate. Valid is left high after acceptance so that back-to-back
  // transactions never see it drop; a drain, or a next call that idles first, lowers it.
  task automatic send_access(
    input opcode_t op, input logic [15:0] addr, input logic [3:0] len,
    input logic [63:0] wdata, input logic set_init, input logic fill_free
  );
    int unsigned    gap;
    access_result_t pred;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_address      <= addr;
    in_length       <= len;
    in_write_data   <= wdata;
    in_set_initial  <= set_init;
    in_init_if_free <= fill_free;
    do @(posedge clk); while (!in_ready);
    // Accepted at this edge: the prediction is made in acceptance order.
    pred        = compute_access_result(op, addr, len, wdata, set_init, fill_free);
    due_results = {due_results, pred};
    n_sent++;
  endtask

  // Stops offering and waits until every owed answer has come back.
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) begin
      if (waited > 50000) begin
        $error("results still owed after %0d cycles: %0d", waited, due_results.size());
        n_errors++;
        break;
      end
      waited++;
      @(posedge clk);
    end
  endtask

  // Writes the fill value through the configuration port, reads it back, and
  // updates the predictor. Only called while no transaction is in flight.
  task automatic write_fill_value(input logic [7:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_FILL;
    cfg_pwdata  <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'd0, value}) begin
      $error("fill_value mismatch: expected %h, got %h", {24'd0, value}, cfg_prdata);
      n_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    fill_byte = value;
    n_fill_writes++;
  endtask

  // Ordinary accesses: free bytes, full and partial writes, image reads, the
  // copy of free bytes on read, a block-crossing access and the top address.
  task automatic test_directed_access();
    send_access(OP_READ,  16'h0000, 4'd1, 64'd0, 1'b0, 1'b0);
    send_access(OP_IMAGE, 16'h0000, 4'd8, 64'd0, 1'b0, 1'b0);
    send_access(OP_WRITE, 16'h0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_access(OP_WRITE, 16'h0008, 4'd8, 64'h0000_0000_0000_0000, 1'b0, 1'b1);
    send_access(OP_READ,  16'h0004, 4'd8, 64'd0, 1'b0, 1'b0);
    // Half written, half free: the free half is copied in and then reads defined.
    send_access(OP_READ,  16'h000C, 4'd8, 64'd0, 1'b0, 1'b1);
    send_access(OP_READ,  16'h000C, 4'd8, 64'd0, 1'b0, 1'b0);
    send_access(OP_IMAGE, 16'h0006, 4'd4, 64'd0, 1'b0, 1'b0);
    // Only the low three bytes of the write data are stored.
    send_access(OP_WRITE, 16'h0020, 4'd3, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0);
    send_access(OP_READ,  16'h001E, 4'd8, 64'd0, 1'b0, 1'b0);
    // An access across the boundary between two 64-byte blocks.
    send_access(OP_WRITE, 16'h003E, 4'd4, 64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 1'b0);
    send_access(OP_READ,  16'h003C, 4'd8, 64'd0, 1'b0, 1'b0);
    send_access(OP_WRITE, 16'hFFF8, 4'd8, 64'h8877_6655_4433_2211, 1'b0, 1'b0);
    send_access(OP_READ,  16'hFFFF, 4'd1, 64'd0, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Every way to get an error answer: bad opcode, length zero or above eight,
  // and an access that runs past the last byte.
  task automatic test_error_cases();
    send_access(OP_BAD,   16'h0000, 4'd4,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_access(OP_WRITE, 16'h0040, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_access(OP_READ,  16'h0040, 4'd9,  64'd0, 1'b0, 1'b1);
    send_access(OP_IMAGE, 16'h0040, 4'd15, 64'd0, 1'b0, 1'b0);
    send_access(OP_WRITE, 16'hFFF9, 4'd8,  64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0);
    send_access(OP_READ,  16'hFFFF, 4'd2,  64'd0, 1'b0, 1'b1);
    // The failed accesses at 0x0040 above must have left those bytes untouched.
    send_access(OP_READ,  16'h0040, 4'd8,  64'd0, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Bytes without an image byte follow the fill value in force at read time,
  // until a read copies it into current memory.
  task automatic test_fill_value_changes();
    write_fill_value(8'hFF);
    send_access(OP_READ,  16'h0100, 4'd8, 64'd0, 1'b0, 1'b0);
    send_access(OP_IMAGE, 16'h001C, 4'd8, 64'd0, 1'b0, 1'b0);
    wait_results_drained();
    write_fill_value(8'h5A);
    send_access(OP_READ,  16'h0100, 4'd8, 64'd0, 1'b0, 1'b1);
    wait_results_drained();
    write_fill_value(8'h00);
    send_access(OP_READ,  16'h0100, 4'd8, 64'd0, 1'b0, 1'b0);
    send_access(OP_IMAGE, 16'h0100, 4'd8, 64'd0, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Random traffic. Most addresses fall in a 256-byte window that moves now and
  // then, so reads meet earlier writes; the rest range over the whole space.
  // About one in eight transactions is an error of some kind.
  task automatic test_random_traffic(input int unsigned count, input int unsigned snd_pct,
                                     input int unsigned rcv_pct, input logic [7:0] fill);
    int unsigned pick;
    int unsigned k;
    logic [15:0] addr;
    logic [3:0]  len;
    opcode_t     op;
    write_fill_value(fill);
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
    for (int n = 0; n < int'(count); n++) begin
      if (n % 128 == 0)
        win_base = ($urandom_range(3) == 0) ? MEM_SIZE - 256 : $urandom_range(MEM_SIZE - 512);
      if ($urandom_range(99) < 85) addr = 16'(win_base + $urandom_range(255));
      else addr = 16'($urandom_range(16'hFFFF));
      len  = 4'($urandom_range(1, MAX_ACCESS_BYTES));
      pick = $urandom_range(99);
      if (pick < 36) op = OP_WRITE;
      else if (pick < 74) op = OP_READ;
      else if (pick < 88) op = OP_IMAGE;
      else begin
        op = opcode_t'($urandom_range(2));
        case ($urandom_range(2))
          0: begin
            op  = OP_BAD;
            len = 4'($urandom_range(15));
          end
          1: len = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
          default: begin
            k    = $urandom_range(1, 7);
            addr = 16'(MEM_SIZE - k);
            len  = 4'($urandom_range(k + 1, 8));
          end
        endcase
      end
      send_access(op, addr, len, {$urandom, $urandom}, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
    wait_results_drained();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering,
  // so the block fills up and must stall its input. The sender then pauses
  // until every owed answer has arrived.
  task automatic test_output_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    hold_len    <= 400;
    hold_toggle <= ~hold_toggle;
    for (int n = 0; n < 48; n++)
      send_access(($urandom_range(1) == 0) ? OP_WRITE : OP_READ,
                  16'($urandom_range(63)), 4'($urandom_range(1, MAX_ACCESS_BYTES)),
                  {$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)));
    wait_results_drained();
  endtask

  // Receiver side: a requested hold-off first, otherwise ready at random.
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Result checker: every transaction on the output is matched against the
  // oldest owed answer, field by field.
  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with nothing owed: read_data %h, status %0d", out_read_data, out_status);
        n_errors++;
      end else begin
        want = due_results.pop_front();
        n_checked++;
        status_count[want.status]++;
        if (out_read_data !== want.data) begin
          $error("read_data mismatch: expected %h, got %h", want.data, out_read_data);
          n_errors++;
        end
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          n_errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_READ;
    in_address      <= '0;
    in_length       <= '0;
    in_write_data   <= '0;
    in_set_initial  <= 1'b0;
    in_init_if_free <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    hold_toggle     <= 1'b0;
    hold_seen       <= 1'b0;
    hold_len        <= 0;
    hold_left       <= 0;
    rcv_idle_pct    <= 0;
    snd_idle_pct    = 0;
    n_errors        = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_fill_writes   = 0;
    fill_byte       = 8'h00;
    for (int a = 0; a < MEM_SIZE; a++) begin
      mem_cur[a]    = 8'h00;
      mem_free[a]   = 1'b1;
      mem_img[a]    = 8'h00;
      mem_img_ok[a] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The block now runs its clearing pass; the send task simply waits for
    // in_ready, while the fill register may already be written.
    write_fill_value(8'h00);
    test_directed_access();
    test_error_cases();
    test_fill_value_changes();
    test_random_traffic(520, 16, 70, 8'($urandom_range(255)));
    test_random_traffic(520, 70, 16, 8'hFF);
    test_random_traffic(520, 0, 0, 8'h00);
    test_output_backpressure();

    wait_results_drained();
    repeat (16) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      n_errors++;
    end
    $display("summary: %0d transactions sent, %0d answers checked (%0d defined, %0d partly",
             n_sent, n_checked, status_count[ST_DEFINED], status_count[ST_SOME_UNDEF]);
    $display("summary: undefined, %0d all free, %0d error), %0d fill value writes",
             status_count[ST_ALL_FREE], status_count[ST_ERROR], n_fill_writes);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the clearing pass.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
